FILE: src/stereo_ten_band_graphic_equalizer_defines.svh
// Assertion macros used by the equalizer top level.
`ifndef STEREO_TEN_BAND_GRAPHIC_EQUALIZER_DEFINES_SVH
`define STEREO_TEN_BAND_GRAPHIC_EQUALIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define GEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("equalizer assertion failed");
`define GEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("equalizer assertion failed");
`else
`define GEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/geq_pkg.sv
`timescale 1ns / 1ps
package geq_pkg;

    localparam int MaxBands    = 10;
    localparam int BandIdxW    = 4;
    localparam int SampleW     = 16;
    localparam int GainW       = 16;
    localparam int GlobalGainW = 15;
    localparam int CfgIdxW     = 2;
    localparam int CfgDataW    = 64;
    localparam int CoefW       = 32;

    localparam logic [CfgIdxW-1:0] RegGains03    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegGains47    = 2'd1;
    localparam logic [CfgIdxW-1:0] RegGains89    = 2'd2;
    localparam logic [CfgIdxW-1:0] RegGlobalGain = 2'd3;

    localparam logic [GlobalGainW-1:0] GlobalGainReset = 15'd8192;

    localparam int StateW = 4;
    localparam logic [StateW-1:0] StIdle     = 4'd0;
    localparam logic [StateW-1:0] StMulA     = 4'd1;
    localparam logic [StateW-1:0] StMulG     = 4'd2;
    localparam logic [StateW-1:0] StMulB     = 4'd3;
    localparam logic [StateW-1:0] StSub      = 4'd4;
    localparam logic [StateW-1:0] StBandOut  = 4'd5;
    localparam logic [StateW-1:0] StMulGain  = 4'd6;
    localparam logic [StateW-1:0] StAcc      = 4'd7;
    localparam logic [StateW-1:0] StMulHi    = 4'd8;
    localparam logic [StateW-1:0] StMulLo    = 4'd9;
    localparam logic [StateW-1:0] StPAdd     = 4'd10;
    localparam logic [StateW-1:0] StResult   = 4'd11;

    typedef logic signed [CoefW-1:0] t_tab [MaxBands];
    typedef logic [MaxBands-1:0][GainW-1:0] t_gains;

    // Coefficients in millionths, band 0 lowest.
    localparam t_tab MicroA = '{
        32'sd3013, 32'sd8490, 32'sd15374, 32'sd29328, 32'sd47918,
        32'sd130408, 32'sd226555, 32'sd344937, 32'sd366438, 32'sd379009
    };
    localparam t_tab MicroB = '{
        32'sd993973, 32'sd983019, 32'sd969252, 32'sd941343, 32'sd904163,
        32'sd739184, 32'sd546889, 32'sd310127, 32'sd267123, 32'sd241981
    };
    localparam t_tab MicroG = '{
        32'sd1993901, 32'sd1982437, 32'sd1967331, 32'sd1934254, 32'sd1884869,
        32'sd1582718, 32'sd1015267, -32'sd181410, -32'sd521151, -32'sd808451
    };

    typedef struct packed {
        logic signed [SampleW-1:0] left_sample;
        logic signed [SampleW-1:0] right_sample;
    } t_in;

    typedef struct packed {
        logic signed [SampleW-1:0] left_out;
        logic signed [SampleW-1:0] right_out;
    } t_out;

    typedef struct packed {
        logic [StateW-1:0]       state;
        logic [BandIdxW-1:0]     band;
        logic signed [CoefW-1:0] coef;
        logic signed [GainW-1:0] gain;
        logic                    load;
        logic                    commit;
    } t_ctl;

    // Rounds each coefficient to the given number of fraction bits, halves away from zero.
    function automatic t_tab coef_tab(input t_tab micro, input int frac);
        t_tab        res;
        logic [63:0] mag;
        logic [63:0] q;
        for (int k = 0; k < MaxBands; k++) begin
            mag = (micro[k] < 0) ? 64'(-64'(micro[k])) : 64'(micro[k]);
            q = ((mag << frac) + 64'd500000) / 64'd1000000;
            res[k] = (micro[k] < 0) ? -$signed(q[CoefW-1:0]) : $signed(q[CoefW-1:0]);
        end
        return res;
    endfunction

endpackage

FILE: src/geq_stream_if.sv
`timescale 1ns / 1ps
interface geq_stream_if #(
    parameter type T = geq_pkg::t_in
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/geq_seq.sv
`timescale 1ns / 1ps
module geq_seq #(
    parameter int BANDS          = 10,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_free,
    input  geq_pkg::t_gains       i_gains,
    output geq_pkg::t_ctl         o_ctl
);

    localparam int BandW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam logic [BandW-1:0] LastBand = BandW'(BANDS - 1);

    localparam geq_pkg::t_tab CoefA = geq_pkg::coef_tab(geq_pkg::MicroA, COEF_FRAC_BITS);
    localparam geq_pkg::t_tab CoefB = geq_pkg::coef_tab(geq_pkg::MicroB, COEF_FRAC_BITS);
    localparam geq_pkg::t_tab CoefG = geq_pkg::coef_tab(geq_pkg::MicroG, COEF_FRAC_BITS);

    logic [geq_pkg::StateW-1:0]       r_state;
    logic [geq_pkg::StateW-1:0]       n_state;
    logic [BandW-1:0]                 r_band;
    logic [BandW-1:0]                 n_band;
    logic signed [geq_pkg::CoefW-1:0] r_coef;
    logic signed [geq_pkg::CoefW-1:0] n_coef;
    logic signed [geq_pkg::GainW-1:0] r_gain;
    logic                             w_load;
    logic                             w_commit;

    assign w_load   = (r_state == geq_pkg::StIdle) && i_in_valid;
    assign w_commit = (r_state == geq_pkg::StResult) && i_out_free;

    always_comb begin
        n_state = r_state;
        n_band  = r_band;
        case (r_state)
            geq_pkg::StIdle: begin
                if (i_in_valid) begin
                    n_state = geq_pkg::StMulA;
                    n_band  = '0;
                end
            end
            geq_pkg::StMulA:    n_state = geq_pkg::StMulG;
            geq_pkg::StMulG:    n_state = geq_pkg::StMulB;
            geq_pkg::StMulB:    n_state = geq_pkg::StSub;
            geq_pkg::StSub:     n_state = geq_pkg::StBandOut;
            geq_pkg::StBandOut: n_state = geq_pkg::StMulGain;
            geq_pkg::StMulGain: begin
                if (r_band == LastBand) begin
                    n_state = geq_pkg::StAcc;
                end else begin
                    n_state = geq_pkg::StMulA;
                    n_band  = r_band + 1'b1;
                end
            end
            geq_pkg::StAcc:     n_state = geq_pkg::StMulHi;
            geq_pkg::StMulHi:   n_state = geq_pkg::StMulLo;
            geq_pkg::StMulLo:   n_state = geq_pkg::StPAdd;
            geq_pkg::StPAdd:    n_state = geq_pkg::StResult;
            geq_pkg::StResult: begin
                if (i_out_free) begin
                    n_state = geq_pkg::StIdle;
                end
            end
            default:            n_state = geq_pkg::StIdle;
        endcase
    end

    always_comb begin
        case (n_state)
            geq_pkg::StMulA: n_coef = CoefA[n_band];
            geq_pkg::StMulG: n_coef = CoefG[n_band];
            geq_pkg::StMulB: n_coef = CoefB[n_band];
            default:         n_coef = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= geq_pkg::StIdle;
            r_band  <= '0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
        r_gain <= i_gains[r_band];
    end

    assign o_in_ready   = (r_state == geq_pkg::StIdle);
    assign o_ctl.state  = r_state;
    assign o_ctl.band   = geq_pkg::BandIdxW'(r_band);
    assign o_ctl.coef   = r_coef;
    assign o_ctl.gain   = r_gain;
    assign o_ctl.load   = w_load;
    assign o_ctl.commit = w_commit;

endmodule

FILE: src/geq_lane.sv
`timescale 1ns / 1ps
module geq_lane #(
    parameter int BANDS          = 10,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  geq_pkg::t_ctl                      i_ctl,
    input  logic signed [geq_pkg::SampleW-1:0] i_sample,
    input  logic [geq_pkg::GlobalGainW-1:0]    i_global_gain,
    output logic signed [geq_pkg::SampleW-1:0] o_result
);

    localparam int BandW    = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int InShift  = 19;
    localparam int HiShift  = 24;
    localparam int OutShift = 34;

    localparam logic signed [31:0] YMax   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] YMin   = 32'sh8000_0000;
    localparam logic signed [47:0] AccMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] AccMin = 48'sh8000_0000_0000;
    localparam logic signed [15:0] OutMax = 16'sh7FFF;
    localparam logic signed [15:0] OutMin = 16'sh8000;
    localparam logic [63:0]        TruncBias = (64'd1 << OutShift) - 64'd1;

    logic [BandW-1:0]   w_band;
    logic signed [15:0] r_x;
    logic signed [15:0] r_x1;
    logic signed [15:0] r_x2;
    logic signed [16:0] w_diff;
    logic signed [47:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_sum;
    logic signed [31:0] r_y;
    logic signed [63:0] r_p;

    logic [63:0]        r_hist [BANDS];
    logic [BANDS-1:0]   r_hval;
    logic [63:0]        r_rd;
    logic               r_rd_ok;
    logic signed [31:0] w_y1;
    logic signed [31:0] w_y2;

    logic signed [31:0] w_op_a;
    logic signed [31:0] w_op_b;
    logic signed [63:0] w_prod;

    logic signed [63:0] w_sh;
    logic signed [31:0] w_y;
    logic signed [63:0] w_acc_sum;
    logic signed [47:0] w_acc_next;
    logic signed [63:0] w_round;
    logic signed [63:0] w_q;
    logic               w_acc_add;

    assign w_band = i_ctl.band[BandW-1:0];
    assign w_diff = {r_x[15], r_x} - {r_x2[15], r_x2};
    assign w_y1   = r_rd_ok ? r_rd[63:32] : '0;
    assign w_y2   = r_rd_ok ? r_rd[31:0] : '0;

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (i_ctl.state)
            geq_pkg::StMulA: begin
                w_op_a = i_ctl.coef;
                w_op_b = {{7{w_diff[16]}}, w_diff, 8'd0};
            end
            geq_pkg::StMulG: begin
                w_op_a = i_ctl.coef;
                w_op_b = w_y1;
            end
            geq_pkg::StMulB: begin
                w_op_a = i_ctl.coef;
                w_op_b = w_y2;
            end
            geq_pkg::StMulGain: begin
                w_op_a = {{16{i_ctl.gain[15]}}, i_ctl.gain};
                w_op_b = r_y;
            end
            geq_pkg::StMulHi: begin
                w_op_a = {{8{r_acc[47]}}, r_acc[47:24]};
                w_op_b = {17'd0, i_global_gain};
            end
            geq_pkg::StMulLo: begin
                w_op_a = {8'd0, r_acc[23:0]};
                w_op_b = {17'd0, i_global_gain};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = 64'(w_op_a) * 64'(w_op_b);

    assign w_sh = r_sum >>> COEF_FRAC_BITS;
    always_comb begin
        if ((&w_sh[63:31]) || !(|w_sh[63:31])) begin
            w_y = w_sh[31:0];
        end else begin
            w_y = w_sh[63] ? YMin : YMax;
        end
    end

    assign w_acc_sum = 64'(r_acc) + r_prod;
    always_comb begin
        if ((&w_acc_sum[63:47]) || !(|w_acc_sum[63:47])) begin
            w_acc_next = w_acc_sum[47:0];
        end else begin
            w_acc_next = w_acc_sum[63] ? AccMin : AccMax;
        end
    end

    assign w_acc_add = ((i_ctl.state == geq_pkg::StMulA) && (i_ctl.band != '0))
                       || (i_ctl.state == geq_pkg::StAcc);

    // Truncation toward zero: negative products are biased before the arithmetic shift.
    assign w_round = r_p + (r_p[63] ? $signed(TruncBias) : 64'sd0);
    assign w_q     = w_round >>> OutShift;
    always_comb begin
        if ((&w_q[63:15]) || !(|w_q[63:15])) begin
            o_result = w_q[15:0];
        end else begin
            o_result = w_q[63] ? OutMin : OutMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1   <= '0;
            r_x2   <= '0;
            r_hval <= '0;
        end else begin
            if (i_ctl.commit) begin
                r_x2 <= r_x1;
                r_x1 <= r_x;
            end
            if (i_ctl.state == geq_pkg::StBandOut) begin
                r_hval[w_band] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_ctl.load) begin
            r_x   <= i_sample;
            r_acc <= 48'(i_sample) <<< InShift;
        end else if (w_acc_add) begin
            r_acc <= w_acc_next;
        end
        case (i_ctl.state)
            geq_pkg::StMulA: begin
                r_rd    <= r_hist[w_band];
                r_rd_ok <= r_hval[w_band];
            end
            geq_pkg::StMulG:    r_sum <= r_prod;
            geq_pkg::StMulB:    r_sum <= r_sum + r_prod;
            geq_pkg::StSub:     r_sum <= r_sum - r_prod;
            geq_pkg::StBandOut: begin
                r_y            <= w_y;
                r_hist[w_band] <= {w_y, w_y1};
            end
            geq_pkg::StMulLo:   r_p <= r_prod <<< HiShift;
            geq_pkg::StPAdd:    r_p <= r_p + r_prod;
            default: ;
        endcase
    end

endmodule

FILE: src/geq_merge.sv
`timescale 1ns / 1ps
module geq_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_commit,
    input  logic signed [geq_pkg::SampleW-1:0] i_results [2],
    output logic                               o_out_free,
    geq_stream_if.source                       o_result
);

    logic           r_valid;
    geq_pkg::t_out  r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_commit) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_data.left_out  <= i_results[0];
            r_data.right_out <= i_results[1];
        end
    end

    assign o_out_free     = !r_valid || o_result.ready;
    assign o_result.valid = r_valid;
    assign o_result.data  = r_data;

endmodule

FILE: src/stereo_ten_band_graphic_equalizer.sv
`timescale 1ns / 1ps
// Channel     Direction  Transfer when        Payload
// i_samples   in         valid && ready       left_sample, right_sample
// o_result    out        valid && ready       left_out, right_out
// i_cfg_*     in         i_cfg_we             register index, write data
//
// One stereo pair is processed at a time, as input is accepted only while idle; the pace
// is set by the single 32 x 32 multiplier in each channel lane, which forms
// every band product and the two halves of the global gain product in turn.
// Reset is synchronous and clears the filter history and the gains (global gain to a quarter).
// A result that is not taken holds the lanes in their final step; input waits meanwhile.
`include "stereo_ten_band_graphic_equalizer_defines.svh"
module stereo_ten_band_graphic_equalizer #(
    parameter int BANDS          = 10,
    parameter int CHANNELS       = 2,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    geq_stream_if.sink                       i_samples,
    geq_stream_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [geq_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [geq_pkg::CfgDataW-1:0]     i_cfg_data
);

    localparam int NumLanes = (CHANNELS < 2) ? CHANNELS : 2;

    geq_pkg::t_gains                     r_gains;
    logic [geq_pkg::GlobalGainW-1:0]     r_global_gain;
    geq_pkg::t_ctl                       w_ctl;
    logic                                w_ready;
    logic                                w_out_free;
    logic signed [geq_pkg::SampleW-1:0]  w_samples [2];
    logic signed [geq_pkg::SampleW-1:0]  w_results [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains       <= '0;
            r_global_gain <= geq_pkg::GlobalGainReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                geq_pkg::RegGains03:    r_gains[3:0]  <= i_cfg_data;
                geq_pkg::RegGains47:    r_gains[7:4]  <= i_cfg_data;
                geq_pkg::RegGains89:    r_gains[9:8]  <= i_cfg_data[31:0];
                geq_pkg::RegGlobalGain: r_global_gain <= i_cfg_data[geq_pkg::GlobalGainW-1:0];
                default: ;
            endcase
        end
    end

    geq_seq #(
        .BANDS          (BANDS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_samples.valid),
        .o_in_ready (w_ready),
        .i_out_free (w_out_free),
        .i_gains    (r_gains),
        .o_ctl      (w_ctl)
    );

    assign i_samples.ready = w_ready;
    assign w_samples[0]    = i_samples.data.left_sample;
    assign w_samples[1]    = i_samples.data.right_sample;

    for (genvar k = 0; k < 2; k++) begin : g_lane
        if (k < NumLanes) begin : g_active
            geq_lane #(
                .BANDS          (BANDS),
                .COEF_FRAC_BITS (COEF_FRAC_BITS)
            ) u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_sample      (w_samples[k]),
                .i_global_gain (r_global_gain),
                .o_result      (w_results[k])
            );
        end else begin : g_absent
            assign w_results[k] = '0;
        end
    end

    geq_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (w_ctl.commit),
        .i_results  (w_results),
        .o_out_free (w_out_free),
        .o_result   (o_result)
    );

    `GEQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_samples.valid && i_samples.ready, !i_samples.ready)
    `GEQ_ASSERT_NEXT(a_commit_shows_result, i_clk, i_rst_n, w_ctl.commit, o_result.valid)
    `GEQ_ASSERT_NEXT(a_commit_frees_input, i_clk, i_rst_n, w_ctl.commit, i_samples.ready)
    `GEQ_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, w_ctl.commit && o_result.valid, o_result.ready)

endmodule

FILE: bench/tb_stereo_ten_band_graphic_equalizer.sv
`timescale 1ns / 1ps
module tb_stereo_ten_band_graphic_equalizer;
    import geq_pkg::*;

    localparam int Bands       = 10;
    localparam int Channels    = 2;
    localparam int CoefFrac    = 22;
    localparam int CycleLimit  = 1_000_000;
    localparam int DrainCycles = 6 * Bands + 20;
    localparam int PhaseItems  = 100;
    localparam int Phases      = 8;

    localparam longint AccMax = 64'sd140737488355327;
    localparam longint AccMin = -AccMax - 64'sd1;

    typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} t_idle;

    typedef struct packed {
        logic                      is_cfg;
        logic [CfgIdxW-1:0]        idx;
        logic [CfgDataW-1:0]       data;
        logic signed [SampleW-1:0] left;
        logic signed [SampleW-1:0] right;
        logic                      typed;
        logic signed [SampleW-1:0] exp_left;
        logic signed [SampleW-1:0] exp_right;
    } t_row;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx  = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    geq_stream_if #(.T(t_in))  samples_if ();
    geq_stream_if #(.T(t_out)) results_if ();

    stereo_ten_band_graphic_equalizer #(
        .BANDS         (Bands),
        .CHANNELS      (Channels),
        .COEF_FRAC_BITS(CoefFrac)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samples (samples_if.sink),
        .o_result  (results_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor copy of the configuration and the filter history.
    logic [63:0]            gains_03;
    logic [63:0]            gains_47;
    logic [31:0]            gains_89;
    logic [GlobalGainW-1:0] global_gain_q;
    int                     lane_x [Channels][2];
    int                     lane_y [Channels][Bands][2];

    t_out  expected_pairs [$];
    int    mismatches  = 0;
    int    cycle_count = 0;
    t_idle idle_mode   = IdleNone;
    t_row  directed_rows [$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint q_coef(input int micro);
        longint mag;
        longint q;
        mag = (micro < 0) ? -longint'(micro) : longint'(micro);
        q = ((mag <<< CoefFrac) + 64'sd500000) / 64'sd1000000;
        return (micro < 0) ? -q : q;
    endfunction

    function automatic longint sat_acc48(input longint v);
        if (v > AccMax) return AccMax;
        if (v < AccMin) return AccMin;
        return v;
    endfunction

    function automatic logic signed [GainW-1:0] gain_of(input int band);
        logic [63:0] word;
        word = (band < 4) ? gains_03 : ((band < 8) ? gains_47 : {32'd0, gains_89});
        return word[16 * (band % 4) +: 16];
    endfunction

    function automatic logic signed [SampleW-1:0] run_lane(input int ch,
                                                           input logic signed [SampleW-1:0] xin);
        longint x;
        longint acc;
        longint diff;
        longint y1;
        longint y2;
        longint s;
        longint y;
        longint p;
        longint r;
        x = xin;
        acc = x * 64'sd524288;
        diff = x - longint'(lane_x[ch][1]);
        for (int b = 0; b < Bands; b++) begin
            y1 = lane_y[ch][b][0];
            y2 = lane_y[ch][b][1];
            s = q_coef(MicroA[b]) * diff * 64'sd256 + q_coef(MicroG[b]) * y1
                - q_coef(MicroB[b]) * y2;
            y = s >>> CoefFrac;
            if (y > 64'sd2147483647) y = 64'sd2147483647;
            if (y < -64'sd2147483648) y = -64'sd2147483648;
            lane_y[ch][b][1] = int'(y1);
            lane_y[ch][b][0] = int'(y);
            acc = sat_acc48(acc + y * longint'(gain_of(b)));
        end
        lane_x[ch][1] = lane_x[ch][0];
        lane_x[ch][0] = int'(x);
        p = acc * longint'({49'd0, global_gain_q});
        r = (p < 0) ? -((-p) >>> 34) : (p >>> 34);
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32768) r = -64'sd32768;
        return r[SampleW-1:0];
    endfunction

    function automatic t_out equalize_pair(input t_in pair);
        t_out res;
        res.left_out  = run_lane(0, pair.left_sample);
        res.right_out = run_lane(1, pair.right_sample);
        return res;
    endfunction

    task automatic clear_predictor();
        gains_03      = '0;
        gains_47      = '0;
        gains_89      = '0;
        global_gain_q = GlobalGainReset;
        for (int c = 0; c < Channels; c++) begin
            lane_x[c][0] = 0;
            lane_x[c][1] = 0;
            for (int b = 0; b < Bands; b++) begin
                lane_y[c][b][0] = 0;
                lane_y[c][b][1] = 0;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic int sender_idle_pct();
        case (idle_mode)
            IdleSender: return 79;
            IdleBoth:   return 16;
            default:    return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IdleReceiver: return 79;
            IdleBoth:     return 16;
            default:      return 0;
        endcase
    endfunction

    // Result side: check each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && results_if.valid && results_if.ready) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch("result transfer with no expected pair waiting");
            end else begin
                want = expected_pairs.pop_front();
                if (results_if.data.left_out !== want.left_out) begin
                    report_mismatch($sformatf("left_out %0d, expected %0d",
                                              results_if.data.left_out, want.left_out));
                end
                if (results_if.data.right_out !== want.right_out) begin
                    report_mismatch($sformatf("right_out %0d, expected %0d",
                                              results_if.data.right_out, want.right_out));
                end
            end
        end
        results_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("stereo_ten_band_graphic_equalizer verification failed");
        $finish;
    end

    task automatic send_pair(input t_in pair, input logic typed, input t_out typed_exp);
        int   gap;
        t_out predicted;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct()) gap++;
        if (gap > 0) begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        samples_if.valid <= 1'b1;
        samples_if.data  <= pair;
        @(posedge i_clk);
        while (!samples_if.ready) @(posedge i_clk);
        predicted = equalize_pair(pair);
        expected_pairs.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic wait_idle();
        samples_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pairs.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegGains03:    gains_03 = data;
            RegGains47:    gains_47 = data;
            RegGains89:    gains_89 = data[31:0];
            RegGlobalGain: global_gain_q = data[GlobalGainW-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] random_gain_word();
        logic [63:0] word;
        int          style;
        word  = {$urandom, $urandom};
        style = $urandom_range(3);
        for (int k = 0; k < 4; k++) begin
            case (style)
                0:       word[16 * k +: 16] = 16'h0000;
                1:       word[16 * k +: 16] = 16'($urandom);
                2:       word[16 * k +: 16] = 16'($urandom_range(4095) - 2048);
                default: word[16 * k +: 16] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            endcase
        end
        return word;
    endfunction

    task automatic configure_random();
        logic [63:0] g;
        write_reg(RegGains03, random_gain_word());
        write_reg(RegGains47, random_gain_word());
        write_reg(RegGains89, random_gain_word());
        g = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       g[GlobalGainW-1:0] = '0;
            1:       g[GlobalGainW-1:0] = '1;
            2:       g[GlobalGainW-1:0] = GlobalGainReset;
            default: ;
        endcase
        write_reg(RegGlobalGain, g);
    endtask

    function automatic logic signed [SampleW-1:0] pick_sample();
        case ($urandom_range(9))
            6:       return 16'sh7FFF;
            7:       return 16'sh8000;
            8, 9:    return 16'($urandom_range(511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_row cfg_row(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
        t_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic t_row sample_row(input logic signed [SampleW-1:0] l,
                                        input logic signed [SampleW-1:0] r);
        t_row row;
        row       = '0;
        row.left  = l;
        row.right = r;
        return row;
    endfunction

    function automatic t_row known_row(input logic signed [SampleW-1:0] l,
                                       input logic signed [SampleW-1:0] r,
                                       input logic signed [SampleW-1:0] el,
                                       input logic signed [SampleW-1:0] er);
        t_row row;
        row           = sample_row(l, r);
        row.typed     = 1'b1;
        row.exp_left  = el;
        row.exp_right = er;
        return row;
    endfunction

    initial begin
        t_in                       pair;
        t_out                      typed_exp;
        t_row                      row;
        int                        tone_period;
        logic signed [SampleW-1:0] amp_l;
        logic signed [SampleW-1:0] amp_r;

        samples_if.valid = 1'b0;
        samples_if.data  = '0;
        clear_predictor();

        // Zero band gains and the reset global gain pass a quarter of the input, truncated toward zero.
        directed_rows.push_back(known_row(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        directed_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sd8191, -16'sd8192));
        directed_rows.push_back(known_row(16'sh8000, 16'sh7FFF, -16'sd8192, 16'sd8191));
        directed_rows.push_back(known_row(-16'sd3, 16'sd3, 16'sd0, 16'sd0));
        directed_rows.push_back(known_row(16'sd5, -16'sd5, 16'sd1, -16'sd1));
        directed_rows.push_back(known_row(-16'sd4, 16'sd4, -16'sd1, 16'sd1));
        // Upper bits of the written word fall outside the register.
        directed_rows.push_back(cfg_row(RegGlobalGain, 64'hFFFF_FFFF_FFFF_0000));
        directed_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0));
        directed_rows.push_back(cfg_row(RegGlobalGain, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(known_row(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        directed_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sd32766, -16'sd32767));
        directed_rows.push_back(cfg_row(RegGains03, 64'h7FFF_7FFF_7FFF_7FFF));
        directed_rows.push_back(cfg_row(RegGains47, 64'h8000_8000_8000_8000));
        directed_rows.push_back(cfg_row(RegGains89, 64'hDEAD_BEEF_7FFF_8000));
        directed_rows.push_back(sample_row(16'sh7FFF, 16'sh8000));
        directed_rows.push_back(sample_row(16'sh8000, 16'sh7FFF));
        directed_rows.push_back(sample_row(16'sh7FFF, 16'sh7FFF));
        directed_rows.push_back(sample_row(16'sh8000, 16'sh8000));
        directed_rows.push_back(sample_row(16'sd0, 16'sd0));
        directed_rows.push_back(cfg_row(RegGlobalGain, 64'd8192));
        directed_rows.push_back(sample_row(16'sh7FFF, 16'sh8000));
        directed_rows.push_back(sample_row(16'sd1, -16'sd1));
        directed_rows.push_back(sample_row(16'sh8000, 16'sh7FFF));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                pair.left_sample    = row.left;
                pair.right_sample   = row.right;
                typed_exp.left_out  = row.exp_left;
                typed_exp.right_out = row.exp_right;
                send_pair(pair, row.typed, typed_exp);
            end
        end

        for (int phase = 0; phase < Phases; phase++) begin
            wait_idle();
            configure_random();
            idle_mode   = t_idle'(phase % 4);
            tone_period = $urandom_range(1) ? $urandom_range(40, 2) : 0;
            amp_l       = pick_sample();
            amp_r       = pick_sample();
            for (int n = 0; n < PhaseItems; n++) begin
                if (phase == 1 && n == PhaseItems / 2) wait_idle();
                if (tone_period != 0 && $urandom_range(3) != 0) begin
                    pair.left_sample  = ((n / tone_period) % 2) ? amp_l : -amp_l;
                    pair.right_sample = ((n / tone_period) % 2) ? -amp_r : amp_r;
                end else begin
                    pair.left_sample  = pick_sample();
                    pair.right_sample = pick_sample();
                end
                send_pair(pair, 1'b0, '0);
            end
        end

        samples_if.valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("stereo_ten_band_graphic_equalizer verification clean");
        end else begin
            $display("stereo_ten_band_graphic_equalizer verification failed");
        end
        $finish;
    end

endmodule
